@@ hdl/alux_pkg.sv @@
// ----------------------------------------------------------------------------
// alux_pkg
// Types and fixed constants of the two-channel ambient light lux calculator:
// band codes, ratio limits, formula coefficients and the divide-by-3125 terms.
// ----------------------------------------------------------------------------
package alux_pkg;

   typedef enum logic [2:0] {
      BAND_LOW  = 3'd0,
      BAND_MID  = 3'd1,
      BAND_HIGH = 3'd2,
      BAND_IR   = 3'd3,
      BAND_NONE = 3'd4
   } band_type;

   localparam int IN_W   = 16;
   localparam int LUX_W  = 20;
   localparam int K_W    = 15;
   localparam int DIV_STEPS = 5;

   // ratio limits, tested as 100*ir <= limit*b
   localparam int RATIO_SCALE = 100;
   localparam int LIM_LOW     = 52;
   localparam int LIM_MID     = 65;
   localparam int LIM_HIGH    = 80;
   localparam int LIM_IR      = 130;
   // largest Q0.15 ratio that can reach the low band
   localparam int K_LOW_MAX   = 17039;

   // coefficients in units of 1e-5
   localparam int K_LOW_BASE = 3150 * 32768;
   localparam int K_LOW_Y    = 5930;
   localparam int COEF_B_MID  = 2290;
   localparam int COEF_I_MID  = 2910;
   localparam int COEF_B_HIGH = 1570;
   localparam int COEF_I_HIGH = 1800;
   localparam int COEF_B_IR   = 338;
   localparam int COEF_I_IR   = 260;

   // 100000 * 2^15 = 3125 * 2^20 and 100000 = 3125 * 2^5
   localparam int DEC_DIV   = 3125;
   localparam int LOW_SHIFT = 20;
   localparam int LIN_SHIFT = 5;
   localparam logic [29:0] RECIP_DIV = 30'd703687441;
   localparam int RECIP_SHIFT = 41;

endpackage

@@ hdl/ambient_light_lux_calc_top.sv @@
// ----------------------------------------------------------------------------
// ambient_light_lux_calc_top
// Converts a broadband / infrared count pair into lux and the ratio band used.
// ----------------------------------------------------------------------------
// Requests arrive on the req_ channel (valid / stall) as a broadband and an
// infrared count; each gives exactly one response on the rsp_ channel carrying
// the lux value (LUX_FRAC_BITS fraction bits, clamped at zero, saturated at the
// top of its 20 bits) and the band 0..3, or 4 for a ratio above 1.30 or a zero
// broadband count.
// The datapath is a ten-stage pipeline: a 15-bit restoring divider for the
// ratio spread over three stages, the k^1.4 table and interpolation, the band
// formula and a reciprocal-multiply divide by 3125. One request is taken every
// cycle unless all stages are full and rsp_stall holds the output.
// Each stage has its own valid bit and advances when it is empty or the stage
// after it moves, so bubbles close up while rsp_stall is high. req_stall rises
// only once all ten stages hold a request.
// Reset clears the valid bits only; there is no other state and no clearing
// pass.
// ----------------------------------------------------------------------------
module ambient_light_lux_calc_top
   import alux_pkg::*;
#(
   parameter int LUX_FRAC_BITS        = 8,
   parameter int POW_TABLE_INDEX_BITS = 6
) (
   input  logic                clock,
   input  logic                reset,
   input  logic                req_valid,
   output logic                req_stall,
   input  logic [IN_W-1:0]     req_broadband_count,
   input  logic [IN_W-1:0]     req_infrared_count,
   output logic                rsp_valid,
   input  logic                rsp_stall,
   output logic [LUX_W-1:0]    rsp_lux_value,
   output logic [2:0]          rsp_ratio_band
);

   localparam int NSTAGE    = 10;
   localparam int POW_SHIFT = K_W - POW_TABLE_INDEX_BITS;
   localparam int ROM_DEPTH = (1 << POW_TABLE_INDEX_BITS) + 1;
   localparam int ROM_AW    = POW_TABLE_INDEX_BITS + 1;
   localparam int U_W       = 43;
   localparam int WW        = U_W + LUX_FRAC_BITS;
   localparam logic [WW-1:0] SAT_LIM = WW'(64'(DEC_DIV) << LUX_W);

   typedef struct packed {
      logic [IN_W-1:0] b;
      logic [IN_W-1:0] ir;
      band_type        band;
      logic [IN_W-1:0] rem;
      logic [K_W-1:0]  q;
   } s1_stage_type;

   typedef struct packed {
      logic [IN_W-1:0] b;
      band_type        band;
      logic [IN_W-1:0] rem;
      logic [K_W-1:0]  q;
      logic [27:0]     pb;
      logic [27:0]     pi;
   } s2_stage_type;

   typedef struct packed {
      logic [IN_W-1:0]    b;
      band_type           band;
      logic [K_W-1:0]     k;
      logic signed [28:0] lin;
   } s3_stage_type;

   typedef struct packed {
      logic [IN_W-1:0]        b;
      band_type               band;
      logic signed [28:0]     lin;
      logic [15:0]            e0;
      logic [15:0]            diff;
      logic [POW_SHIFT-1:0]   frac;
   } s4_stage_type;

   typedef struct packed {
      logic [IN_W-1:0]    b;
      band_type           band;
      logic signed [28:0] lin;
      logic [15:0]        y;
   } s5_stage_type;

   typedef struct packed {
      logic [IN_W-1:0]    b;
      band_type           band;
      logic signed [28:0] lin;
      logic signed [29:0] c;
   } s6_stage_type;

   typedef struct packed {
      band_type           band;
      logic signed [46:0] v;
   } s7_stage_type;

   typedef struct packed {
      band_type    band;
      logic        neg;
      logic        sat;
      logic [31:0] n32;
   } s8_stage_type;

   typedef struct packed {
      band_type         band;
      logic             neg;
      logic             sat;
      logic [LUX_W-1:0] qe;
      logic [31:0]      n32;
   } s9_stage_type;

   typedef struct packed {
      band_type         band;
      logic [LUX_W-1:0] lux;
   } s10_stage_type;

   // k^1.4 table entry: x*z/2^12 with z the integer fifth root of x^2*2^30
   function automatic logic [15:0] pow_entry(input int unsigned j);
      longint unsigned x, t, lo, hi, mid, p;
      x  = longint'(j) << POW_SHIFT;
      t  = (x * x) << 30;
      lo = 0;
      hi = 4096;
      while (lo < hi) begin
         mid = (lo + hi + 1) >> 1;
         p   = mid * mid * mid * mid * mid;
         if (p <= t) begin
            lo = mid;
         end else begin
            hi = mid - 1;
         end
      end
      return 16'((x * lo) >> 12);
   endfunction

   // DIV_STEPS quotient bits of the restoring divider
   function automatic logic [IN_W+K_W-1:0] div_steps(input logic [IN_W-1:0] rem_i,
                                                    input logic [K_W-1:0]  q_i,
                                                    input logic [IN_W-1:0] den);
      logic [IN_W:0]   sh;
      logic [IN_W-1:0] r;
      logic [K_W-1:0]  q;
      r = rem_i;
      q = q_i;
      for (int i = 0; i < DIV_STEPS; i++) begin
         sh = {r, 1'b0};
         if (sh >= {1'b0, den}) begin
            r = IN_W'(sh - {1'b0, den});
            q = {q[K_W-2:0], 1'b1};
         end else begin
            r = sh[IN_W-1:0];
            q = {q[K_W-2:0], 1'b0};
         end
      end
      return {r, q};
   endfunction

   logic [15:0] pow_rom [ROM_DEPTH];

   for (genvar j = 0; j < ROM_DEPTH; j++) begin : g_rom
      localparam logic [15:0] ENTRY = pow_entry(j);
      assign pow_rom[j] = ENTRY;
   end

   logic [NSTAGE-1:0] vld_ff;
   logic [NSTAGE-1:0] vld_in;
   logic [NSTAGE:0]   rdy;

   s1_stage_type  s1_ff,  s1_in;
   s2_stage_type  s2_ff,  s2_in;
   s3_stage_type  s3_ff,  s3_in;
   s4_stage_type  s4_ff,  s4_in;
   s5_stage_type  s5_ff,  s5_in;
   s6_stage_type  s6_ff,  s6_in;
   s7_stage_type  s7_ff,  s7_in;
   s8_stage_type  s8_ff,  s8_in;
   s9_stage_type  s9_ff,  s9_in;
   s10_stage_type s10_ff, s10_in;

   // handshake: a stage moves when it is empty or the next one moves
   always_comb begin
      rdy[NSTAGE] = !rsp_stall;
      for (int i = NSTAGE - 1; i >= 0; i--) begin
         rdy[i] = !vld_ff[i] || rdy[i+1];
      end
   end

   assign vld_in    = {vld_ff[NSTAGE-2:0], req_valid};
   assign req_stall = !rdy[0];
   assign rsp_valid = vld_ff[NSTAGE-1];

   always_ff @(posedge clock) begin
      if (reset) begin
         vld_ff <= '0;
      end else begin
         for (int i = 0; i < NSTAGE; i++) begin
            if (rdy[i]) begin
               vld_ff[i] <= vld_in[i];
            end
         end
      end
   end

   // stage 1: band choice and the top divider bits
   logic [23:0] ir100;
   logic [23:0] b_ext;

   always_comb begin
      ir100 = 24'(req_infrared_count) * 24'(RATIO_SCALE);
      b_ext = 24'(req_broadband_count);
      s1_in.b  = req_broadband_count;
      s1_in.ir = req_infrared_count;
      if (req_broadband_count == '0) begin
         s1_in.band = BAND_NONE;
      end else if (ir100 <= b_ext * 24'(LIM_LOW)) begin
         s1_in.band = BAND_LOW;
      end else if (ir100 <= b_ext * 24'(LIM_MID)) begin
         s1_in.band = BAND_MID;
      end else if (ir100 <= b_ext * 24'(LIM_HIGH)) begin
         s1_in.band = BAND_HIGH;
      end else if (ir100 <= b_ext * 24'(LIM_IR)) begin
         s1_in.band = BAND_IR;
      end else begin
         s1_in.band = BAND_NONE;
      end
      {s1_in.rem, s1_in.q} = div_steps(req_infrared_count, '0, req_broadband_count);
   end

   // stage 2: middle divider bits, linear band products
   logic [11:0] coef_b;
   logic [11:0] coef_i;

   always_comb begin
      case (s1_ff.band)
         BAND_MID: begin
            coef_b = 12'(COEF_B_MID);
            coef_i = 12'(COEF_I_MID);
         end
         BAND_HIGH: begin
            coef_b = 12'(COEF_B_HIGH);
            coef_i = 12'(COEF_I_HIGH);
         end
         BAND_IR: begin
            coef_b = 12'(COEF_B_IR);
            coef_i = 12'(COEF_I_IR);
         end
         default: begin
            coef_b = '0;
            coef_i = '0;
         end
      endcase
      s2_in.b    = s1_ff.b;
      s2_in.band = s1_ff.band;
      {s2_in.rem, s2_in.q} = div_steps(s1_ff.rem, s1_ff.q, s1_ff.b);
      s2_in.pb = {12'd0, s1_ff.b} * {16'd0, coef_b};
      s2_in.pi = {12'd0, s1_ff.ir} * {16'd0, coef_i};
   end

   // stage 3: last divider bits give k in Q0.15
   logic [IN_W-1:0] rem3;

   always_comb begin
      s3_in.b    = s2_ff.b;
      s3_in.band = s2_ff.band;
      {rem3, s3_in.k} = div_steps(s2_ff.rem, s2_ff.q, s2_ff.b);
      s3_in.lin = $signed({1'b0, s2_ff.pb}) - $signed({1'b0, s2_ff.pi});
   end

   // stage 4: table read either side of k
   logic [ROM_AW-1:0] rom_idx;
   logic [ROM_AW-1:0] rom_nxt;
   logic [15:0]       e1;

   always_comb begin
      rom_idx    = {1'b0, s3_ff.k[K_W-1:POW_SHIFT]};
      rom_nxt    = rom_idx + 1'b1;
      e1         = pow_rom[rom_nxt];
      s4_in.b    = s3_ff.b;
      s4_in.band = s3_ff.band;
      s4_in.lin  = s3_ff.lin;
      s4_in.e0   = pow_rom[rom_idx];
      s4_in.diff = e1 - s4_in.e0;
      s4_in.frac = s3_ff.k[POW_SHIFT-1:0];
   end

   // stage 5: linear interpolation
   logic [15+POW_SHIFT:0] interp;

   always_comb begin
      interp     = (16+POW_SHIFT)'(s4_ff.diff) * (16+POW_SHIFT)'(s4_ff.frac);
      s5_in.b    = s4_ff.b;
      s5_in.band = s4_ff.band;
      s5_in.lin  = s4_ff.lin;
      s5_in.y    = s4_ff.e0 + interp[15+POW_SHIFT:POW_SHIFT];
   end

   // stage 6: low band factor 3150*2^15 - 5930*y
   logic [29:0] y_term;

   always_comb begin
      y_term     = {14'd0, s5_ff.y} * 30'(K_LOW_Y);
      s6_in.b    = s5_ff.b;
      s6_in.band = s5_ff.band;
      s6_in.lin  = s5_ff.lin;
      s6_in.c    = $signed(30'(K_LOW_BASE)) - $signed(y_term);
   end

   // stage 7: scale by the broadband count for the low band, else pass the linear result
   logic signed [46:0] b_sx;
   logic signed [46:0] c_sx;

   always_comb begin
      b_sx       = $signed({31'd0, s6_ff.b});
      c_sx       = $signed({{17{s6_ff.c[29]}}, s6_ff.c});
      s7_in.band = s6_ff.band;
      if (s6_ff.band == BAND_LOW) begin
         s7_in.v = b_sx * c_sx;
      end else begin
         s7_in.v = {{18{s6_ff.lin[28]}}, s6_ff.lin};
      end
   end

   // stage 8: fraction bits in, power-of-two part of the divisor out
   logic [WW-1:0] w_sh;
   logic [WW-1:0] n_full;

   always_comb begin
      w_sh = {{LUX_FRAC_BITS{1'b0}}, s7_ff.v[U_W-1:0]} << LUX_FRAC_BITS;
      if (s7_ff.band == BAND_LOW) begin
         n_full = w_sh >> LOW_SHIFT;
      end else begin
         n_full = w_sh >> LIN_SHIFT;
      end
      s8_in.band = s7_ff.band;
      s8_in.neg  = s7_ff.v[46];
      s8_in.sat  = n_full >= SAT_LIM;
      s8_in.n32  = n_full[31:0];
   end

   // stage 9: quotient estimate by reciprocal, low by at most one
   logic [61:0] recip_prod;

   always_comb begin
      recip_prod = {30'd0, s8_ff.n32} * {32'd0, RECIP_DIV};
      s9_in.band = s8_ff.band;
      s9_in.neg  = s8_ff.neg;
      s9_in.sat  = s8_ff.sat;
      s9_in.qe   = recip_prod[RECIP_SHIFT+LUX_W-1:RECIP_SHIFT];
      s9_in.n32  = s8_ff.n32;
   end

   // stage 10: correct the estimate, clamp and saturate
   logic [31:0] q_mul;
   logic [31:0] q_rem;

   always_comb begin
      q_mul = {12'd0, s9_ff.qe} * 32'(DEC_DIV);
      q_rem = s9_ff.n32 - q_mul;
      s10_in.band = s9_ff.band;
      if (s9_ff.band == BAND_NONE || s9_ff.neg) begin
         s10_in.lux = '0;
      end else if (s9_ff.sat) begin
         s10_in.lux = '1;
      end else if (q_rem >= 32'(DEC_DIV)) begin
         s10_in.lux = s9_ff.qe + 1'b1;
      end else begin
         s10_in.lux = s9_ff.qe;
      end
   end

   always_ff @(posedge clock) begin
      if (rdy[0]) begin
         s1_ff <= s1_in;
      end
      if (rdy[1]) begin
         s2_ff <= s2_in;
      end
      if (rdy[2]) begin
         s3_ff <= s3_in;
      end
      if (rdy[3]) begin
         s4_ff <= s4_in;
      end
      if (rdy[4]) begin
         s5_ff <= s5_in;
      end
      if (rdy[5]) begin
         s6_ff <= s6_in;
      end
      if (rdy[6]) begin
         s7_ff <= s7_in;
      end
      if (rdy[7]) begin
         s8_ff <= s8_in;
      end
      if (rdy[8]) begin
         s9_ff <= s9_in;
      end
      if (rdy[9]) begin
         s10_ff <= s10_in;
      end
   end

   assign rsp_lux_value  = s10_ff.lux;
   assign rsp_ratio_band = s10_ff.band;

   // out of range or zero broadband always reports zero lux
   assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_ratio_band == BAND_NONE |-> rsp_lux_value == '0)
      else $error("lux not zero for band none");

   // input is held off only when every stage holds a request
   assert property (@(posedge clock) disable iff (reset)
      req_stall |-> &vld_ff)
      else $error("request stalled with a free stage");

   // no backpressure from the output means none at the input
   assert property (@(posedge clock) disable iff (reset)
      !rsp_stall |-> !req_stall)
      else $error("request stalled while response side is free");

   // divider result for the low band stays within its ratio limit
   assert property (@(posedge clock) disable iff (reset)
      vld_ff[2] && s3_ff.band == BAND_LOW |-> s3_ff.k <= K_W'(K_LOW_MAX))
      else $error("low band ratio beyond limit");

endmodule
